// File: rtl/rlpe_pkg.sv
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types, constants and helpers of the RGB LED pulse encoder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

    localparam int CHAN_W   = 8;
    localparam int TICK_W   = 15;
    localparam int WORD_W   = 3 * CHAN_W;
    localparam int PULSES   = WORD_W;
    localparam int CNT_W    = $clog2(PULSES + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TICK_W;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH      = 3'd5;

    // reset values
    localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 15'd16;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 15'd34;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 15'd32;
    localparam logic [TICK_W-1:0] ONE_LOW_RST    = 15'd18;
    localparam logic [TICK_W-1:0] LATCH_RST      = 15'd2000;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] latch;
    } t_tick_cfg;

    // scaled pixel in wire order: green, red, blue, msb first
    typedef struct packed {
        logic [WORD_W-1:0] bits;
        logic              last;
    } t_pixel;

    // exact floor(p / 255) for any product of two bytes
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
        logic [2*CHAN_W:0] s;
        s = {1'b0, p} + {9'd0, p[2*CHAN_W-1:CHAN_W]} + 17'd1;
        return s[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

// File: rtl/rlpe_front.sv
// ----------------------------------------------------------------------------
// rlpe_front
// Accepts pixels, scales each channel by brightness and packs the word.
// ----------------------------------------------------------------------------
module rlpe_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rlpe_pkg::CHAN_W-1:0]  i_brightness,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rlpe_pkg::CHAN_W-1:0]  i_red,
    input  logic [rlpe_pkg::CHAN_W-1:0]  i_green,
    input  logic [rlpe_pkg::CHAN_W-1:0]  i_blue,
    input  logic                         i_last_pixel,
    output logic                         o_push,
    output rlpe_pkg::t_pixel             o_pixel,
    input  logic                         i_q_ready
);
    import rlpe_pkg::*;

    logic                  r_valid;
    logic [2*CHAN_W-1:0]   r_prod_r, r_prod_g, r_prod_b;
    logic                  r_last;
    logic                  accept;

    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;

    // products are registered; the /255 runs on the way into the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_r <= i_red   * i_brightness;
            r_prod_g <= i_green * i_brightness;
            r_prod_b <= i_blue  * i_brightness;
            r_last   <= i_last_pixel;
        end
    end

    assign o_push      = r_valid && i_q_ready;
    assign o_pixel.bits = {div255(r_prod_g), div255(r_prod_r), div255(r_prod_b)};
    assign o_pixel.last = r_last;

endmodule

// File: rtl/rlpe_queue.sv
// ----------------------------------------------------------------------------
// rlpe_queue
// Short FIFO of packed pixel words between front and back.
// ----------------------------------------------------------------------------
module rlpe_queue #(
    parameter int DEPTH = rlpe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rlpe_pkg::t_pixel  i_pixel,
    output logic              o_ready,
    input  logic              i_pop,
    output rlpe_pkg::t_pixel  o_pixel,
    output logic              o_valid
);
    import rlpe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    t_pixel             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_pixel = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

endmodule

// File: rtl/rlpe_back.sv
// ----------------------------------------------------------------------------
// rlpe_back
// Serializes a pixel word into pulse words, plus the latch word on the last.
// ----------------------------------------------------------------------------
module rlpe_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rlpe_pkg::t_tick_cfg          i_ticks,
    input  logic                         i_q_valid,
    input  rlpe_pkg::t_pixel             i_pixel,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_first_level,
    output logic [rlpe_pkg::TICK_W-1:0]  o_first_ticks,
    output logic                         o_second_level,
    output logic [rlpe_pkg::TICK_W-1:0]  o_second_ticks,
    output logic                         o_last_item
);
    import rlpe_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(PULSES - 1);
    localparam logic [CNT_W-1:0] LATCH    = CNT_W'(PULSES);

    logic               r_busy;
    logic [WORD_W-1:0]  r_bits;
    logic               r_last;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic               r_first_level;
    logic [TICK_W-1:0]  r_first_ticks;
    logic [TICK_W-1:0]  r_second_ticks;
    logic               r_last_item;

    logic               load, finishing, cur_bit, is_latch, fin_item;

    assign load      = r_busy && (!r_out_valid || i_ready);
    assign is_latch  = (r_cnt == LATCH);
    assign fin_item  = is_latch || ((r_cnt == LAST_BIT) && !r_last);
    assign finishing = load && fin_item;
    assign o_pop     = i_q_valid && (!r_busy || finishing);
    assign cur_bit   = r_bits[WORD_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (finishing) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word held msb first; shift left per pulse
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= i_pixel.bits;
            r_last <= i_pixel.last;
            r_cnt  <= '0;
        end else if (load) begin
            r_bits <= {r_bits[WORD_W-2:0], 1'b0};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last_item <= fin_item;
            if (is_latch) begin
                r_first_level  <= 1'b0;
                r_first_ticks  <= i_ticks.latch;
                r_second_ticks <= '0;
            end else begin
                r_first_level  <= 1'b1;
                r_first_ticks  <= cur_bit ? i_ticks.one_high : i_ticks.zero_high;
                r_second_ticks <= cur_bit ? i_ticks.one_low  : i_ticks.zero_low;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_level  = r_first_level;
    assign o_first_ticks  = r_first_ticks;
    assign o_second_level = 1'b0;
    assign o_second_ticks = r_second_ticks;
    assign o_last_item    = r_last_item;

endmodule

// File: rtl/rgb_led_pulse_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder
// Pixel to pulse-word encoder for a single-wire serial RGB LED strip.
// ----------------------------------------------------------------------------
// Each accepted pixel is scaled by brightness, sent green-red-blue msb first
// as 24 pulse words, and followed by one latch word when marked last. The
// output serializer produces one word per cycle unless the receiver stalls
// or the queue is empty. The front scales the next pixel meanwhile, and
// the queue of QUEUE_DEPTH words lets the input run ahead. Products pass a
// register, the queue and the serializer to a registered output word. The
// config port is always ready; write registers only while the block is idle.
module rgb_led_pulse_encoder #(
    parameter int QUEUE_DEPTH = rlpe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rlpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rlpe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rlpe_pkg::CHAN_W-1:0]      i_red,
    input  logic [rlpe_pkg::CHAN_W-1:0]      i_green,
    input  logic [rlpe_pkg::CHAN_W-1:0]      i_blue,
    input  logic                             i_last_pixel,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_first_level,
    output logic [rlpe_pkg::TICK_W-1:0]      o_first_ticks,
    output logic                             o_second_level,
    output logic [rlpe_pkg::TICK_W-1:0]      o_second_ticks,
    output logic                             o_last_item
);
    import rlpe_pkg::*;

    logic [CHAN_W-1:0] r_brightness;
    t_tick_cfg         r_ticks;
    logic              front_push, q_ready, q_valid, q_pop;
    t_pixel            front_pixel, q_pixel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness      <= BRIGHTNESS_RST;
            r_ticks.zero_high <= ZERO_HIGH_RST;
            r_ticks.zero_low  <= ZERO_LOW_RST;
            r_ticks.one_high  <= ONE_HIGH_RST;
            r_ticks.one_low   <= ONE_LOW_RST;
            r_ticks.latch     <= LATCH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BRIGHTNESS: r_brightness      <= i_cfg_data[CHAN_W-1:0];
                REG_ZERO_HIGH:  r_ticks.zero_high <= i_cfg_data;
                REG_ZERO_LOW:   r_ticks.zero_low  <= i_cfg_data;
                REG_ONE_HIGH:   r_ticks.one_high  <= i_cfg_data;
                REG_ONE_LOW:    r_ticks.one_low   <= i_cfg_data;
                REG_LATCH:      r_ticks.latch     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rlpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_brightness (r_brightness),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .o_push       (front_push),
        .o_pixel      (front_pixel),
        .i_q_ready    (q_ready)
    );

    rlpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_pixel (front_pixel),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_pixel (q_pixel),
        .o_valid (q_valid)
    );

    rlpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ticks        (r_ticks),
        .i_q_valid      (q_valid),
        .i_pixel        (q_pixel),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_last_item    (o_last_item)
    );

endmodule

// File: dv/tb_rgb_led_pulse_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_led_pulse_encoder
// Self-checking bench for the RGB LED pulse encoder.
// ----------------------------------------------------------------------------
// Pixels go in over valid/ready in random bursts. Each accepted pixel is
// turned into its expected pulse words (24, plus a latch word on a last
// pixel) by a local encoder on its own register copy (typed rows give the
// wire word by hand). A short directed table runs first at reset settings.
// Random frames follow under several register settings, extremes included.
// Each output word is compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module tb_rgb_led_pulse_encoder;
    import rlpe_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 55;
    localparam int NUM_DIR        = 14;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic              first_level;
        logic [TICK_W-1:0] first_ticks;
        logic              second_level;
        logic [TICK_W-1:0] second_ticks;
        logic              last_item;
    } t_pulse_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
        logic              typed;    // grb below is the hand-worked wire word
        logic [WORD_W-1:0] grb;
    } t_dir_row;

    // wire order is green, red, blue; typed rows assume brightness 255
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 24'h000000},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 24'hffffff},
        '{8'hff, 8'h00, 8'h00, 1'b0, 1'b1, 24'h00ff00},
        '{8'h00, 8'hff, 8'h00, 1'b0, 1'b1, 24'hff0000},
        '{8'h00, 8'h00, 8'hff, 1'b0, 1'b1, 24'h0000ff},
        '{8'h80, 8'h01, 8'h7f, 1'b0, 1'b1, 24'h01807f},
        '{8'h01, 8'h80, 8'hfe, 1'b0, 1'b1, 24'h8001fe},
        '{8'h55, 8'haa, 8'h5a, 1'b1, 1'b1, 24'haa555a},
        '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 24'h000000},
        '{8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 24'hffffff},
        '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 24'h000000},
        '{8'hc3, 8'h3c, 8'ha5, 1'b1, 1'b0, 24'h000000},
        '{8'h7f, 8'hfe, 8'h01, 1'b0, 1'b0, 24'h000000},
        '{8'haa, 8'h55, 8'h0f, 1'b1, 1'b0, 24'h000000}
    };

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [CHAN_W-1:0]     i_red          = '0;
    logic [CHAN_W-1:0]     i_green        = '0;
    logic [CHAN_W-1:0]     i_blue         = '0;
    logic                  i_last_pixel   = 1'b0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic                  o_first_level;
    logic [TICK_W-1:0]     o_first_ticks;
    logic                  o_second_level;
    logic [TICK_W-1:0]     o_second_ticks;
    logic                  o_last_item;

    // local copy of the register file
    logic [CHAN_W-1:0] brightness = BRIGHTNESS_RST;
    logic [TICK_W-1:0] zero_high  = ZERO_HIGH_RST;
    logic [TICK_W-1:0] zero_low   = ZERO_LOW_RST;
    logic [TICK_W-1:0] one_high   = ONE_HIGH_RST;
    logic [TICK_W-1:0] one_low    = ONE_LOW_RST;
    logic [TICK_W-1:0] latch_len  = LATCH_RST;

    t_pulse_word pending_pulses [$];
    int          fail_cnt   = 0;
    int          burst_left = 0;

    rgb_led_pulse_encoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_last_pixel   (i_last_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_last_item    (o_last_item)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // expected pulse words
    // ------------------------------------------------------------------
    function automatic void push_grb(input logic [WORD_W-1:0] grb, input logic last);
        t_pulse_word w;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            w.first_level  = 1'b1;
            w.second_level = 1'b0;
            w.first_ticks  = grb[k] ? one_high : zero_high;
            w.second_ticks = grb[k] ? one_low : zero_low;
            w.last_item    = (k == 0) && !last;
            pending_pulses.push_back(w);
        end
        if (last) begin
            w.first_level  = 1'b0;
            w.first_ticks  = latch_len;
            w.second_level = 1'b0;
            w.second_ticks = '0;
            w.last_item    = 1'b1;
            pending_pulses.push_back(w);
        end
    endfunction

    function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] v);
        int unsigned prod;
        prod = v * brightness;
        return (brightness == 8'd255) ? v : CHAN_W'(prod / 255);
    endfunction

    function automatic void encode_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                         input logic [CHAN_W-1:0] b, input logic last);
        push_grb({dim_channel(g), dim_channel(r), dim_channel(b)}, last);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic last,
                              input logic typed, input logic [WORD_W-1:0] grb);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_red        <= r;
        i_green      <= g;
        i_blue       <= b;
        i_last_pixel <= last;
        do @(posedge i_clk); while (!o_ready);
        if (typed)
            push_grb(grb, last);
        else
            encode_pixel(r, g, b, last);
    endtask

    // stop sending and wait for every expected word, then let the pipe settle
    task automatic drain(input int settle);
        i_valid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BRIGHTNESS: brightness = data[CHAN_W-1:0];
            REG_ZERO_HIGH:  zero_high  = data;
            REG_ZERO_LOW:   zero_low   = data;
            REG_ONE_HIGH:   one_high   = data;
            REG_ONE_LOW:    one_low    = data;
            REG_LATCH:      latch_len  = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] br, input logic [TICK_W-1:0] zh,
                             input logic [TICK_W-1:0] zl, input logic [TICK_W-1:0] oh,
                             input logic [TICK_W-1:0] ol, input logic [TICK_W-1:0] lt);
        write_reg(REG_BRIGHTNESS, br);
        write_reg(REG_ZERO_HIGH, zh);
        write_reg(REG_ZERO_LOW, zl);
        write_reg(REG_ONE_HIGH, oh);
        write_reg(REG_ONE_LOW, ol);
        write_reg(REG_LATCH, lt);
    endtask

    function automatic logic [TICK_W-1:0] any_ticks();
        return TICK_W'($urandom_range(0, 32767));
    endfunction

    // ------------------------------------------------------------------
    // receiver: stall pattern changes mode every so often
    // ------------------------------------------------------------------
    int unsigned rx_cycle = 0;
    int unsigned rx_left  = 0;
    int unsigned rx_mode  = 0;

    always @(posedge i_clk) begin
        t_pulse_word got;
        t_pulse_word want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_first_level, o_first_ticks, o_second_level, o_second_ticks, o_last_item};
            if (pending_pulses.size() == 0) begin
                $error("unexpected pulse word: %p", got);
                fail_cnt++;
            end else begin
                want = pending_pulses.pop_front();
                if (got.first_level !== want.first_level) begin
                    $error("first_level: expected %0d, actual %0d",
                           want.first_level, got.first_level);
                    fail_cnt++;
                end
                if (got.first_ticks !== want.first_ticks) begin
                    $error("first_ticks: expected %0d, actual %0d",
                           want.first_ticks, got.first_ticks);
                    fail_cnt++;
                end
                if (got.second_level !== want.second_level) begin
                    $error("second_level: expected %0d, actual %0d",
                           want.second_level, got.second_level);
                    fail_cnt++;
                end
                if (got.second_ticks !== want.second_ticks) begin
                    $error("second_ticks: expected %0d, actual %0d",
                           want.second_ticks, got.second_ticks);
                    fail_cnt++;
                end
                if (got.last_item !== want.last_item) begin
                    $error("last_item: expected %0d, actual %0d",
                           want.last_item, got.last_item);
                    fail_cnt++;
                end
            end
        end

        rx_cycle <= rx_cycle + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= $urandom_range(0, 1);
            2:       i_ready <= (rx_cycle % 5) != 0;
            default: i_ready <= (rx_cycle % 24) < 4;   // long stalls
        endcase
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any accepted pixel, word or register write ends the run
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[rgb_led_pulse_encoder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int frame_left;
        logic last;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings
        for (int i = 0; i < NUM_DIR; i++) begin
            send_pixel(DIR_ROWS[i].red, DIR_ROWS[i].green, DIR_ROWS[i].blue,
                       DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].grb);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain(SETTLE_CYCLES);
            case (ph)
                0: write_all(15'd0, '0, '1, '1, '0, '0);
                1: write_all(15'd1, any_ticks(), any_ticks(), any_ticks(), any_ticks(),
                             any_ticks());
                2: write_all(15'd254, '1, '1, '1, '1, '1);
                3: begin
                    write_all(15'd128, any_ticks(), any_ticks(), any_ticks(), any_ticks(),
                              any_ticks());
                    write_reg(REG_SPARE_LO, '1);
                    write_reg(REG_SPARE_HI, any_ticks());
                end
                // upper data bits on the brightness write are dropped
                4: write_all(15'h7f80, any_ticks(), any_ticks(), any_ticks(), any_ticks(),
                             any_ticks());
                default: write_all(15'd255, any_ticks(), any_ticks(), any_ticks(),
                                   any_ticks(), any_ticks());
            endcase

            frame_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (frame_left == 0)
                    frame_left = $urandom_range(1, 10);
                last = (frame_left == 1);
                frame_left--;
                send_pixel(pick_level(), pick_level(), pick_level(), last, 1'b0, '0);
                if ((ph == 1 || ph == 4) && n == PHASE_ITEMS / 2)
                    drain(0);
            end
        end

        drain(TAIL_CYCLES);
        if (fail_cnt == 0)
            $display("[rgb_led_pulse_encoder] OK");
        else
            $display("[rgb_led_pulse_encoder] ERROR");
        $finish;
    end

endmodule
